### src/sdsf_pkg.sv
// Shared types, constants and segment table of the seven-segment formatter
`timescale 1ns / 1ps

package sdsf_pkg;

  // magnitude after clamping fits in 14 bits (9999 max)
  localparam int MAG_W = 14;

  localparam logic signed [15:0] VALUE_MAX = 16'sd9999;
  localparam logic signed [15:0] VALUE_MIN = -16'sd999;

  // reciprocal of ten for magnitudes below 2**16: floor(x / 10) = (x * 52429) >> 19
  localparam logic [15:0] RECIP_TEN = 16'd52429;
  localparam int RECIP_SHIFT = 19;

  localparam logic [7:0] SEG_BLANK = 8'h00;
  localparam logic [7:0] SEG_MINUS = 8'h01;

  typedef logic [MAG_W-1:0] mag_t;
  typedef logic [3:0] bcd_t;
  typedef logic [7:0] seg_t;

  // decimal digit to segment pattern
  function automatic seg_t digit_segments(input bcd_t d);
    seg_t s;
    case (d)
      4'd0: s = 8'h7E;
      4'd1: s = 8'h30;
      4'd2: s = 8'h6D;
      4'd3: s = 8'h79;
      4'd4: s = 8'h33;
      4'd5: s = 8'h5B;
      4'd6: s = 8'h5F;
      4'd7: s = 8'h70;
      4'd8: s = 8'h7F;
      4'd9: s = 8'h7B;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

### src/signed_decimal_seven_segment_formatter_core.sv
// Top level: signed value to four seven-segment display command words
`timescale 1ns / 1ps

// Takes a signed 16-bit value on start when busy is low, clamps it to -999..9999 and
// sends four display words, one per cycle, at digit addresses 4, 3, 2, 1 with last_word
// high on address 1. The receiver cannot stall: each word is on the ports for exactly
// one cycle while word_valid is high. The first word is registered through the clamp,
// three divide-by-ten stages, segment lookup and output register. A new value can
// be taken before the last one has left: the result port carries four words per value,
// so busy stays high after each accept until the gap counter runs down, while earlier
// values keep moving through the pipeline.
module signed_decimal_seven_segment_formatter_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] value,
  output logic               word_valid,
  output logic [2:0]         digit_address,
  output logic [7:0]         segments,
  output logic               last_word
);

  logic [1:0] gap;
  logic       accept;

  // stage 1: clamp and magnitude
  logic               s1_valid;
  logic               s1_neg;
  sdsf_pkg::mag_t     s1_mag;
  logic signed [15:0] clamped;
  logic signed [15:0] negated;

  // divide stages
  logic           a_valid, b_valid, c_valid;
  sdsf_pkg::mag_t a_quot, b_quot, c_quot;
  sdsf_pkg::bcd_t a_rem, b_rem, c_rem;
  logic           a_neg, b_neg, c_neg;
  sdsf_pkg::bcd_t b_d0, c_d0, c_d1;
  logic           b_nz1, c_nz1, c_nz2;

  // stage 5: segment patterns, leftmost first
  logic                   s5_valid;
  sdsf_pkg::seg_t [3:0]   s5_places;

  // output serializer
  sdsf_pkg::seg_t [2:0]   pending;
  logic [1:0]             remaining;

  assign accept = start && !busy;
  assign busy   = (gap != 2'd0);

  // spacing of accepts: the gap counter is loaded on each accept and holds busy high
  always_ff @(posedge clk) begin
    if (rst) begin
      gap <= 2'd0;
    end else if (accept) begin
      gap <= 2'd3;
    end else if (gap != 2'd0) begin
      gap <= gap - 2'd1;
    end
  end

  // clamp to the display range
  always_comb begin
    if (value > sdsf_pkg::VALUE_MAX) begin
      clamped = sdsf_pkg::VALUE_MAX;
    end else if (value < sdsf_pkg::VALUE_MIN) begin
      clamped = sdsf_pkg::VALUE_MIN;
    end else begin
      clamped = value;
    end
    negated = -clamped;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_neg <= clamped[15];
    s1_mag <= clamped[15] ? negated[sdsf_pkg::MAG_W-1:0] : clamped[sdsf_pkg::MAG_W-1:0];
  end

  // three digits by repeated division by ten
  sdsf_div10 u_div_a (
    .clk(clk), .rst(rst), .in_valid(s1_valid), .in_value(s1_mag),
    .out_valid(a_valid), .out_quot(a_quot), .out_rem(a_rem)
  );

  sdsf_div10 u_div_b (
    .clk(clk), .rst(rst), .in_valid(a_valid), .in_value(a_quot),
    .out_valid(b_valid), .out_quot(b_quot), .out_rem(b_rem)
  );

  sdsf_div10 u_div_c (
    .clk(clk), .rst(rst), .in_valid(b_valid), .in_value(b_quot),
    .out_valid(c_valid), .out_quot(c_quot), .out_rem(c_rem)
  );

  // side data kept in step with the divide stages
  always_ff @(posedge clk) begin
    a_neg <= s1_neg;
    b_neg <= a_neg;
    b_d0  <= a_rem;
    b_nz1 <= (a_quot != '0);
    c_neg <= b_neg;
    c_d0  <= b_d0;
    c_d1  <= b_rem;
    c_nz1 <= b_nz1;
    c_nz2 <= (b_quot != '0);
  end

  // segment lookup; a place shows a digit while the remaining value is nonzero
  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else begin
      s5_valid <= c_valid;
    end
  end

  // units always shown, tens from c_d1, hundreds from the last remainder
  always_ff @(posedge clk) begin
    s5_places[3] <= sdsf_pkg::digit_segments(c_d0);
    s5_places[2] <= c_nz1 ? sdsf_pkg::digit_segments(c_d1) : sdsf_pkg::SEG_BLANK;
    s5_places[1] <= c_nz2 ? sdsf_pkg::digit_segments(c_rem) : sdsf_pkg::SEG_BLANK;
    if (c_neg) begin
      s5_places[0] <= sdsf_pkg::SEG_MINUS;
    end else if (c_quot != '0) begin
      s5_places[0] <= sdsf_pkg::digit_segments(c_quot[3:0]);
    end else begin
      s5_places[0] <= sdsf_pkg::SEG_BLANK;
    end
  end

  // serializer: first word on arrival, then three more from the pending row
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
      remaining  <= 2'd0;
    end else if (s5_valid) begin
      word_valid <= 1'b1;
      remaining  <= 2'd3;
    end else if (remaining != 2'd0) begin
      word_valid <= 1'b1;
      remaining  <= remaining - 2'd1;
    end else begin
      word_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s5_valid) begin
      digit_address <= 3'd4;
      segments      <= s5_places[0];
      last_word     <= 1'b0;
      pending[0]    <= s5_places[1];
      pending[1]    <= s5_places[2];
      pending[2]    <= s5_places[3];
    end else if (remaining != 2'd0) begin
      digit_address <= {1'b0, remaining};
      segments      <= pending[0];
      last_word     <= (remaining == 2'd1);
      pending[0]    <= pending[1];
      pending[1]    <= pending[2];
      pending[2]    <= sdsf_pkg::SEG_BLANK;
    end
  end

endmodule

### src/sdsf_div10.sv
// One registered divide-by-ten stage: quotient and remainder of a magnitude
`timescale 1ns / 1ps

module sdsf_div10 (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  sdsf_pkg::mag_t in_value,
  output logic          out_valid,
  output sdsf_pkg::mag_t out_quot,
  output sdsf_pkg::bcd_t out_rem
);

  localparam int PROD_W = sdsf_pkg::MAG_W + 16;

  logic [PROD_W-1:0] prod;
  sdsf_pkg::mag_t    quot;
  sdsf_pkg::mag_t    times_ten;
  sdsf_pkg::mag_t    rem_wide;

  // quotient by reciprocal multiply, remainder by shift-add back-multiply
  assign prod      = PROD_W'(in_value) * PROD_W'(sdsf_pkg::RECIP_TEN);
  assign quot      = sdsf_pkg::MAG_W'(prod >> sdsf_pkg::RECIP_SHIFT);
  assign times_ten = (quot << 3) + (quot << 1);
  assign rem_wide  = in_value - times_ten;

  // valid travels with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_quot <= quot;
    out_rem  <= rem_wide[3:0];
  end

endmodule

### dv/tb_signed_decimal_seven_segment_formatter_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the signed decimal seven-segment formatter core
module tb_signed_decimal_seven_segment_formatter_core;

  localparam int PLACES = 4;
  localparam int DIRECTED_ITEMS = 22;
  localparam int RANDOM_ITEMS = 460;
  localparam int QUIET_FIRST = 150;
  localparam int QUIET_LAST = 280;
  localparam int PAUSE_AT = 330;
  localparam int IDLE_PCT = 8;
  localparam int STALL_LIMIT = 1000;
  localparam int TAIL_CYCLES = 20;

  typedef struct packed {
    logic [2:0]     digit_address;
    sdsf_pkg::seg_t segments;
    logic           last_word;
  } display_word_t;

  // places holds the four patterns, leftmost place in the top byte
  typedef struct packed {
    logic signed [15:0] value;
    logic               known;
    logic [31:0]        places;
  } stim_row_t;

  localparam sdsf_pkg::seg_t DIGIT_PATTERN [10] = '{
    8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70, 8'h7F, 8'h7B
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic signed [15:0] value = '0;
  logic               busy;
  logic               word_valid;
  logic [2:0]         digit_address;
  logic [7:0]         segments;
  logic               last_word;

  display_word_t pending_words [$];
  int mismatches = 0;
  int stall_cycles = 0;
  int idle_pct = IDLE_PCT;

  // directed items: extremes, clamping, zero, sign, inner zeros
  stim_row_t directed_rows [DIRECTED_ITEMS] = '{
    '{16'sd0,      1'b1, 32'h0000007E},
    '{16'sd9999,   1'b1, 32'h7B7B7B7B},
    '{16'sd10000,  1'b1, 32'h7B7B7B7B},
    '{16'sd32767,  1'b1, 32'h7B7B7B7B},
    '{-16'sd999,   1'b1, 32'h017B7B7B},
    '{-16'sd1000,  1'b1, 32'h017B7B7B},
    '{-16'sd32768, 1'b1, 32'h017B7B7B},
    '{16'sd1,      1'b1, 32'h00000030},
    '{-16'sd1,     1'b1, 32'h01000030},
    '{16'sd105,    1'b0, 32'h0},
    '{16'sd100,    1'b0, 32'h0},
    '{16'sd1000,   1'b0, 32'h0},
    '{16'sd1234,   1'b0, 32'h0},
    '{16'sd5678,   1'b0, 32'h0},
    '{16'sd9000,   1'b0, 32'h0},
    '{16'sd90,     1'b0, 32'h0},
    '{-16'sd5,     1'b0, 32'h0},
    '{-16'sd10,    1'b0, 32'h0},
    '{-16'sd100,   1'b0, 32'h0},
    '{-16'sd45,    1'b0, 32'h0},
    '{16'sd8,      1'b0, 32'h0},
    '{16'sh5555,   1'b0, 32'h0}
  };

  signed_decimal_seven_segment_formatter_core uut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .value         (value),
    .word_valid    (word_valid),
    .digit_address (digit_address),
    .segments      (segments),
    .last_word     (last_word)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // clamp and convert to the four place patterns, leftmost first
  function automatic logic [31:0] format_display(input logic signed [15:0] v);
    int             n;
    int unsigned    mag;
    int             lowest;
    sdsf_pkg::seg_t places [PLACES];
    n = v;
    if (n > 9999) n = 9999;
    if (n < -999) n = -999;
    for (int k = 0; k < PLACES; k++) places[k] = sdsf_pkg::SEG_BLANK;
    if (n == 0) begin
      places[PLACES-1] = DIGIT_PATTERN[0];
    end else begin
      lowest = 0;
      if (n < 0) begin
        places[0] = sdsf_pkg::SEG_MINUS;
        lowest = 1;
        mag = -n;
      end else begin
        mag = n;
      end
      for (int p = PLACES - 1; p >= lowest && mag != 0; p--) begin
        places[p] = DIGIT_PATTERN[mag % 10];
        mag = mag / 10;
      end
    end
    return {places[0], places[1], places[2], places[3]};
  endfunction

  // four words per item, address 4 down to 1
  function automatic void queue_words(input logic [31:0] pats);
    display_word_t w;
    for (int k = 0; k < PLACES; k++) begin
      w.digit_address = 3'(PLACES - k);
      w.segments = pats[31 - 8*k -: 8];
      w.last_word = (k == PLACES - 1);
      pending_words.push_back(w);
    end
  endfunction

  // mix of in-range, small, full-width, near-limit and round values
  function automatic logic signed [15:0] pick_value();
    int r;
    case ($urandom_range(5))
      0, 1: r = $urandom_range(10998) - 999;
      2: r = $urandom_range(40) - 20;
      3: r = $urandom_range(65535);
      4: begin
        if ($urandom_range(1)) r = 9980 + $urandom_range(40);
        else r = -1020 + $urandom_range(40);
      end
      default: begin
        r = $urandom_range(9) * (10 ** $urandom_range(3));
        if ($urandom_range(1)) r = -r;
      end
    endcase
    return 16'(r);
  endfunction

  // offer one item, with random idle cycles ahead of it
  task automatic send_value(input logic signed [15:0] v, input logic [31:0] pats);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    value <= v;
    do @(posedge clk); while (busy);
    queue_words(pats);
  endtask

  // hold off until every expected word has come out
  task automatic drain_pending();
    start <= 1'b0;
    do @(posedge clk); while (pending_words.size() != 0);
  endtask

  // stimulus
  initial begin
    logic signed [15:0] v;
    logic [31:0]        pats;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      pats = directed_rows[i].known ? directed_rows[i].places
                                    : format_display(directed_rows[i].value);
      send_value(directed_rows[i].value, pats);
    end
    drain_pending();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_pct = (i >= QUIET_FIRST && i < QUIET_LAST) ? 0 : IDLE_PCT;
      if (i == PAUSE_AT) drain_pending();
      v = pick_value();
      send_value(v, format_display(v));
    end

    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // word checker and stall watchdog
  always @(posedge clk) begin : check_words
    display_word_t exp_word;
    if (!rst) begin
      if (word_valid) begin
        if (pending_words.size() == 0) begin
          $error("unexpected word: digit_address %0d segments %h last_word %0b",
                 digit_address, segments, last_word);
          mismatches++;
        end else begin
          exp_word = pending_words.pop_front();
          if (digit_address !== exp_word.digit_address) begin
            $error("digit_address: expected %0d, actual %0d",
                   exp_word.digit_address, digit_address);
            mismatches++;
          end
          if (segments !== exp_word.segments) begin
            $error("segments: expected %h, actual %h", exp_word.segments, segments);
            mismatches++;
          end
          if (last_word !== exp_word.last_word) begin
            $error("last_word: expected %0b, actual %0b", exp_word.last_word, last_word);
            mismatches++;
          end
        end
      end
      if (word_valid || (start && !busy)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

endmodule
